// ----- hdl/ffa_pkg.sv -----
// ffa_pkg: shared types and constants for the first-fit free-list allocator
// used by ffa_cell and first_fit_free_list_allocator_top
package ffa_pkg;
  localparam logic [31:0] PageMaskLow  = 32'h0000_0fff;
  localparam logic [31:0] PageMaskHigh = 32'hffff_f000;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatNoFit   = 2'd1;
  localparam logic [1:0] StatLost    = 2'd2;

  // shift operation broadcast to every cell
  localparam logic [1:0] OpHold  = 2'd0;
  localparam logic [1:0] OpLeft  = 2'd1;  // take the right neighbor (close up)
  localparam logic [1:0] OpRight = 2'd2;  // take the left neighbor (open a gap)

  typedef struct packed {
    logic [1:0]  op;
    logic        wr;
    logic [31:0] wr_start;
    logic [31:0] wr_size;
  } cell_ctl_t;
endpackage

// ----- hdl/ffa_cell.sv -----
// ffa_cell: one table entry (start, size); shifts to/from its neighbors
// depends on ffa_pkg
module ffa_cell (
  input  logic                  clk_i,
  input  ffa_pkg::cell_ctl_t    ctl_i,
  input  logic                  shift_en_i,
  input  logic [31:0]           left_start_i,
  input  logic [31:0]           left_size_i,
  input  logic [31:0]           right_start_i,
  input  logic [31:0]           right_size_i,
  output logic [31:0]           start_o,
  output logic [31:0]           size_o
);
  import ffa_pkg::*;
  logic [31:0] start_q, size_q;

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      start_q <= ctl_i.wr_start;
      size_q  <= ctl_i.wr_size;
    end else if (shift_en_i) begin
      case (ctl_i.op)
        OpLeft: begin
          start_q <= right_start_i;
          size_q  <= right_size_i;
        end
        OpRight: begin
          start_q <= left_start_i;
          size_q  <= left_size_i;
        end
        default: ;
      endcase
    end
  end

  assign start_o = start_q;
  assign size_o  = size_q;
endmodule

// ----- hdl/first_fit_free_list_allocator_top.sv -----
// Sequence per item: a scan of the cell chain one entry a cycle until a fit or an insertion
// point is found or the end is reached, a shift of the chain, a fetch of the first entry
// again, and a free-total pass one entry a cycle, after which the result is presented.
// Throughput: one item at a time; the next is accepted once the result register is free.
// The scan and the free-total pass read the chain through one registered read port.
// Reset clears the entry count, loss counters, page_round and handshake state; cells hold
// undefined data until written.
module first_fit_free_list_allocator_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [31:0] region_addr_i,
  input  logic [31:0] request_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] alloc_addr_o,
  output logic [1:0]  status_o,
  output logic [31:0] free_total_o,
  output logic [8:0]  region_count_o,
  output logic [31:0] lost_count_o,
  output logic [31:0] lost_bytes_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffa_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StShift = 3'd2;
  localparam logic [2:0] StSum   = 3'd3;
  localparam logic [2:0] StLoad  = 3'd4;

  logic [2:0]    state_q;
  logic          page_round_q;
  logic          kind_q;
  logic [31:0]   addr_q, size_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_q, idx_d;   // scan / sum position
  logic [31:0]   lost_events_q, lost_total_q;
  logic [31:0]   total_q;
  logic [31:0]   res_addr_q;
  logic [1:0]    res_stat_q;
  logic          out_valid_q;
  // shift window: cells with index in [lo, hi] move
  logic [CW-1:0] sh_lo_q, sh_hi_q;
  logic [1:0]    sh_op_q;
  logic          wr_en_q;
  logic [IW-1:0] wr_idx_q;
  logic [31:0]   wr_start_q, wr_size_q;
  // registered read of the entry at idx and the entry before it
  logic [31:0]   rd_start_q, rd_size_q;
  logic [31:0]   prv_start_q, prv_size_q;

  logic [31:0] cell_start [TABLE_DEPTH];
  logic [31:0] cell_size  [TABLE_DEPTH];

  // chain of cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cell_ctl_t ctl;
    logic      sh_en;
    logic [31:0] ls, lz, rs, rz;
    assign ctl.op       = sh_op_q;
    assign ctl.wr       = wr_en_q && (state_q == StShift) && (wr_idx_q == IW'(g));
    assign ctl.wr_start = wr_start_q;
    assign ctl.wr_size  = wr_size_q;
    assign sh_en = (state_q == StShift) && (CW'(g) >= sh_lo_q) && (CW'(g) <= sh_hi_q);
    if (g == 0) begin : g_l0
      assign ls = cell_start[g];
      assign lz = cell_size[g];
    end else begin : g_l
      assign ls = cell_start[g-1];
      assign lz = cell_size[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_rn
      assign rs = cell_start[g];
      assign rz = cell_size[g];
    end else begin : g_r
      assign rs = cell_start[g+1];
      assign rz = cell_size[g+1];
    end
    ffa_cell u_cell (
      .clk_i, .ctl_i(ctl), .shift_en_i(sh_en),
      .left_start_i(ls), .left_size_i(lz), .right_start_i(rs), .right_size_i(rz),
      .start_o(cell_start[g]), .size_o(cell_size[g])
    );
  end

  // scanned entry and its predecessor
  logic [IW-1:0] cur_i, prv_i;
  logic [31:0]   cur_start, cur_size, prv_start, prv_size;
  logic          at_end, has_prev, adv;
  assign cur_i     = idx_q[IW-1:0];
  assign prv_i     = cur_i - IW'(1);
  assign cur_start = rd_start_q;
  assign cur_size  = rd_size_q;
  assign prv_start = prv_start_q;
  assign prv_size  = prv_size_q;
  assign at_end    = (idx_q >= count_q);
  assign has_prev  = (idx_q != '0);

  // scan moves on while no fit (allocate) or no larger start (free) is seen
  assign adv = !at_end && ((kind_q == KindAlloc) ? (cur_size < size_q)
                                                 : !(cur_start > addr_q));

  // next scan / sum position, also the read address
  always_comb begin
    case (state_q)
      StScan:  idx_d = adv ? idx_q + CW'(1) : idx_q;
      StSum:   idx_d = at_end ? idx_q : idx_q + CW'(1);
      StLoad:  idx_d = idx_q;
      default: idx_d = '0;
    endcase
  end

  // read port and predecessor capture
  always_ff @(posedge clk_i) begin
    rd_start_q <= cell_start[idx_d[IW-1:0]];
    rd_size_q  <= cell_size[idx_d[IW-1:0]];
    if (state_q == StScan && adv) begin
      prv_start_q <= rd_start_q;
      prv_size_q  <= rd_size_q;
    end
  end

  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign pready     = 1'b1;
  assign prdata     = (paddr == 2'd0) ? {31'd0, page_round_q} : 32'd0;

  logic [31:0] rnd_size;
  assign rnd_size = page_round_q ? ((request_size_i + PageMaskLow) & PageMaskHigh)
                                 : request_size_i;

  logic [31:0] prv_end, new_end;
  assign prv_end = prv_start + prv_size;
  assign new_end = addr_q + size_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      page_round_q  <= 1'b0;
      count_q       <= '0;
      lost_events_q <= '0;
      lost_total_q  <= '0;
      out_valid_q   <= 1'b0;
      wr_en_q       <= 1'b0;
      sh_op_q       <= OpHold;
    end else begin
      idx_q <= idx_d;
      if (psel && penable && pwrite && paddr == 2'd0) page_round_q <= pwdata[0];
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i && !in_stall_o) begin
            kind_q     <= kind_i;
            addr_q     <= region_addr_i;
            size_q     <= rnd_size;
            res_addr_q <= '0;
            res_stat_q <= StatOk;
            sh_op_q    <= OpHold;
            wr_en_q    <= 1'b0;
            state_q    <= StScan;
          end
        end
        StScan: begin
          if (kind_q == KindAlloc) begin
            if (at_end) begin
              res_stat_q <= StatNoFit;
              state_q    <= StShift;
            end else if (cur_size >= size_q) begin
              res_addr_q <= cur_start;
              if (cur_size == size_q) begin
                sh_op_q <= OpLeft;
                sh_lo_q <= idx_q;
                sh_hi_q <= count_q - CW'(1);
                count_q <= count_q - CW'(1);
              end else begin
                wr_en_q    <= 1'b1;
                wr_idx_q   <= cur_i;
                wr_start_q <= cur_start + size_q;
                wr_size_q  <= cur_size - size_q;
              end
              state_q <= StShift;
            end
          end else if (at_end || cur_start > addr_q) begin
            // insertion point found at idx_q
            state_q <= StShift;
            if (has_prev && prv_end == addr_q) begin
              wr_en_q    <= 1'b1;
              wr_idx_q   <= prv_i;
              wr_start_q <= prv_start;
              if (!at_end && new_end == cur_start) begin
                wr_size_q <= prv_size + size_q + cur_size;
                sh_op_q   <= OpLeft;
                sh_lo_q   <= idx_q;
                sh_hi_q   <= count_q - CW'(1);
                count_q   <= count_q - CW'(1);
              end else begin
                wr_size_q <= prv_size + size_q;
              end
            end else if (!at_end && new_end == cur_start) begin
              wr_en_q    <= 1'b1;
              wr_idx_q   <= cur_i;
              wr_start_q <= addr_q;
              wr_size_q  <= cur_size + size_q;
            end else if (count_q < CW'(TABLE_DEPTH)) begin
              // the insert cell stays out of the shift window, so both land together
              sh_op_q    <= OpRight;
              sh_lo_q    <= idx_q + CW'(1);
              sh_hi_q    <= count_q;
              count_q    <= count_q + CW'(1);
              wr_en_q    <= 1'b1;
              wr_idx_q   <= cur_i;
              wr_start_q <= addr_q;
              wr_size_q  <= size_q;
            end else begin
              res_stat_q    <= StatLost;
              lost_events_q <= lost_events_q + 32'd1;
              lost_total_q  <= lost_total_q + size_q;
            end
          end
        end
        StShift: begin
          sh_op_q <= OpHold;
          total_q <= '0;
          state_q <= StLoad;
        end
        StLoad: begin
          // first entry is fetched again after the shift
          state_q <= StSum;
        end
        StSum: begin
          if (at_end) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end else begin
            total_q <= total_q + cur_size;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // the merge-with-both case writes entry idx-1 while it removes entry idx,
  // so the shift and write use different cells in the same cycle

  assign out_valid_o    = out_valid_q;
  assign alloc_addr_o   = res_addr_q;
  assign status_o       = res_stat_q;
  assign free_total_o   = total_q;
  assign region_count_o = 9'(count_q);
  assign lost_count_o   = lost_events_q;
  assign lost_bytes_o   = lost_total_q;
endmodule
